FILE: design/imuad_pkg.sv
// Shared types and constants for the IMU angle packet parser.
// No dependencies.
package imuad_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeAccel = 8'h51;

  // tenths = raw * 1800 >> 15
  localparam logic [10:0] AngleScale = 11'd1800;
  localparam int          AngleShift = 15;

  localparam logic [2:0] TrailerLen = 3'd7;
  localparam logic [4:0] DpOffset   = 5'd20;

  // Reciprocal constants, exact for 12-bit operands: x/10 and x/100 as (x*K)>>19
  localparam logic [15:0] RecipTen     = 16'd52429;
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int          RecipShift   = 19;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_LOW  = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_e;

  // Angle with its two reciprocal quotients
  typedef struct packed {
    logic [11:0] tenths;
    logic [8:0]  whole;     // tenths / 10
    logic [5:0]  upper;     // tenths / 100
  } quot_t;

endpackage

FILE: design/imuad_parser.sv
// Frame parser: header hunt, type check, low/high byte capture, trailer skip.
// Holds the raw angle stage register. Depends on imuad_pkg.
module imuad_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        raw_valid_o,
  input  logic        raw_ready_i,
  output logic [15:0] raw_o
);
  import imuad_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  low_q, low_d;
  logic [2:0]  skip_q, skip_d;
  logic        raw_valid_q, raw_valid_d;
  logic [15:0] raw_q, raw_d;
  logic        accept;
  logic        raw_free;

  assign raw_free   = !raw_valid_q || raw_ready_i;
  // Only the high byte needs room in the raw stage
  assign in_ready_o = (phase_q != PH_HIGH) || raw_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d     = phase_q;
    low_d       = low_q;
    skip_d      = skip_q;
    raw_d       = raw_q;
    raw_valid_d = raw_valid_q && !raw_ready_i;
    if (accept) begin
      case (phase_q)
        PH_TYPE: begin
          if (rx_byte_i == TypeAngle) begin
            phase_d = PH_LOW;
          end else if (rx_byte_i == TypeAccel) begin
            phase_d = PH_HUNT;
          end
        end
        PH_LOW: begin
          low_d   = rx_byte_i;
          phase_d = PH_HIGH;
        end
        PH_HIGH: begin
          raw_d       = {rx_byte_i, low_q};
          raw_valid_d = 1'b1;
          skip_d      = TrailerLen;
          phase_d     = PH_SKIP;
        end
        PH_SKIP: begin
          skip_d = skip_q - 3'd1;
          if (skip_d == 3'd0) begin
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = (rx_byte_i == HdrByte) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      low_q       <= 8'd0;
      skip_q      <= 3'd0;
      raw_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      low_q       <= low_d;
      skip_q      <= skip_d;
      raw_valid_q <= raw_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
  end

  assign raw_valid_o = raw_valid_q;
  assign raw_o       = raw_q;

endmodule

FILE: design/imuad_scale.sv
// Two pipeline stages: scale raw angle to tenths, then reciprocal quotients.
// Depends on imuad_pkg.
module imuad_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  raw_valid_i,
  output logic                  raw_ready_o,
  input  logic [15:0]           raw_i,
  output logic                  quot_valid_o,
  input  logic                  quot_ready_i,
  output imuad_pkg::quot_t      quot_o
);
  import imuad_pkg::*;

  logic        ten_valid_q;
  logic [11:0] ten_q;
  logic        quot_valid_q;
  quot_t       quot_q;
  logic        ten_ready;
  logic [26:0] scaled;
  logic [27:0] prod_ten;
  logic [24:0] prod_hun;

  assign ten_ready   = !quot_valid_q || quot_ready_i;
  assign raw_ready_o = !ten_valid_q || ten_ready;

  assign scaled   = 27'(raw_i) * 27'(AngleScale);
  assign prod_ten = 28'(ten_q) * 28'(RecipTen);
  assign prod_hun = 25'(ten_q) * 25'(RecipHundred);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_valid_q  <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (raw_ready_o) begin
        ten_valid_q <= raw_valid_i;
      end
      if (ten_ready) begin
        quot_valid_q <= ten_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_ready_o && raw_valid_i) begin
      ten_q <= scaled[AngleShift +: 12];
    end
    if (ten_ready && ten_valid_q) begin
      quot_q.tenths <= ten_q;
      quot_q.whole  <= prod_ten[RecipShift +: 9];
      quot_q.upper  <= prod_hun[RecipShift +: 6];
    end
  end

  assign quot_valid_o = quot_valid_q;
  assign quot_o       = quot_q;

endmodule

FILE: design/imuad_digits.sv
// Output register: splits quotients into display digit codes.
// Depends on imuad_pkg.
module imuad_digits (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              quot_valid_i,
  output logic              quot_ready_o,
  input  imuad_pkg::quot_t  quot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [11:0]       angle_tenths_o,
  output logic [3:0]        tenths_digit_o,
  output logic [4:0]        ones_code_o,
  output logic [5:0]        upper_part_o
);
  import imuad_pkg::*;

  logic        out_valid_q;
  logic [11:0] angle_q;
  logic [3:0]  tdig_q;
  logic [4:0]  ones_q;
  logic [5:0]  upper_q;
  logic [11:0] tdig_full;
  logic [8:0]  ones_full;

  assign quot_ready_o = !out_valid_q || out_ready_i;

  // remainders by shift-add multiples of ten
  assign tdig_full = quot_i.tenths - ({quot_i.whole, 3'b000} + {2'b00, quot_i.whole, 1'b0});
  assign ones_full = quot_i.whole - ({quot_i.upper, 3'b000} + {2'b00, quot_i.upper, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (quot_ready_o) begin
      out_valid_q <= quot_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quot_ready_o && quot_valid_i) begin
      angle_q <= quot_i.tenths;
      tdig_q  <= tdig_full[3:0];
      ones_q  <= {1'b0, ones_full[3:0]} + DpOffset;
      upper_q <= quot_i.upper;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign angle_tenths_o = angle_q;
  assign tenths_digit_o = tdig_q;
  assign ones_code_o    = ones_q;
  assign upper_part_o   = upper_q;

endmodule

FILE: design/imu_angle_packet_to_digits.sv
// Top level of the IMU angle packet parser with display-digit split.
// Instantiates imuad_parser, imuad_scale, imuad_digits; uses imuad_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  input    | in_valid_i / in_ready_o  | rx_byte_i
//  result   | out_valid_o / out_ready_i| angle_tenths_o, tenths_digit_o,
//           |                          | ones_code_o, upper_part_o, blank_code_o
//
// One byte is taken per cycle while in_ready_o is high. A result passes through
// the raw, scale, quotient and output registers after its high byte; the scale
// multiply and the reciprocal multiplies each own one stage.
// Reset (async, active low) returns the parser to the header hunt and empties
// the pipeline. A stalled result backs up stage by stage; bytes other than a
// high byte are still taken while the pipeline is full.
module imu_angle_packet_to_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] angle_tenths_o,
  output logic [3:0]  tenths_digit_o,
  output logic [4:0]  ones_code_o,
  output logic [5:0]  upper_part_o,
  output logic        blank_code_o
);
  import imuad_pkg::*;

  logic        raw_valid, raw_ready;
  logic [15:0] raw;
  logic        quot_valid, quot_ready;
  quot_t       quot;

  imuad_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .raw_valid_o (raw_valid),
    .raw_ready_i (raw_ready),
    .raw_o       (raw)
  );

  imuad_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .raw_valid_i  (raw_valid),
    .raw_ready_o  (raw_ready),
    .raw_i        (raw),
    .quot_valid_o (quot_valid),
    .quot_ready_i (quot_ready),
    .quot_o       (quot)
  );

  imuad_digits u_digits (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .quot_valid_i   (quot_valid),
    .quot_ready_o   (quot_ready),
    .quot_i         (quot),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angle_tenths_o (angle_tenths_o),
    .tenths_digit_o (tenths_digit_o),
    .ones_code_o    (ones_code_o),
    .upper_part_o   (upper_part_o)
  );

  assign blank_code_o = 1'b0;

endmodule

FILE: design/imuad_checker.sv
// Port-level checker for imu_angle_packet_to_digits, attached by bind.
// Depends only on the top level's ports.
module imuad_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] angle_tenths_o,
  input logic [3:0]  tenths_digit_o,
  input logic [4:0]  ones_code_o,
  input logic [5:0]  upper_part_o,
  input logic        blank_code_o
);

  // result stays valid, and its angle, ones code and tenths digit stay put, while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_tenths_o)
      && $stable(ones_code_o) && $stable(tenths_digit_o))
    else $error("stalled result changed");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tenths_digit_o <= 4'd9 && ones_code_o >= 5'd20
      && ones_code_o <= 5'd29 && upper_part_o <= 6'd35 && !blank_code_o)
    else $error("digit code out of range");

  // digits recombine into the angle
  a_recombine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (14'(upper_part_o) * 14'd100 + 14'(ones_code_o - 5'd20) * 14'd10
      + 14'(tenths_digit_o)) == 14'(angle_tenths_o))
    else $error("digits do not match angle");

  // an edge seen in reset leaves the result channel empty
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind imu_angle_packet_to_digits imuad_port_checker u_imuad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .angle_tenths_o (angle_tenths_o),
  .tenths_digit_o (tenths_digit_o),
  .ones_code_o    (ones_code_o),
  .upper_part_o   (upper_part_o),
  .blank_code_o   (blank_code_o)
);
